/* hdl/mcb_pkg.sv */
package mcb_pkg;

   localparam int PIX_W      = 32;
   localparam int ADDR_IN_W  = 17;
   localparam int DIM_OUT_W  = 9;
   localparam int CFG_W      = 9;
   localparam int LSEL_W     = 4;
   localparam int CHAN_N     = 4;
   localparam int CSR_IDX_W  = 2;

   typedef enum logic [1:0] {
      OP_LOAD  = 2'd0,
      OP_BUILD = 2'd1,
      OP_READ  = 2'd2,
      OP_QUERY = 2'd3
   } op_type;

   localparam logic [CSR_IDX_W-1:0] REG_WIDTH_IN  = 2'd0;
   localparam logic [CSR_IDX_W-1:0] REG_HEIGHT_IN = 2'd1;
   localparam logic [CSR_IDX_W-1:0] REG_MIPS      = 2'd2;
   localparam logic [CSR_IDX_W-1:0] REG_CHANNELS  = 2'd3;

   typedef enum logic [4:0] {
      CMD_NONE,
      CMD_LOAD,
      CMD_READ,
      CMD_READ_RESP,
      CMD_QUERY_RESP,
      CMD_LAYOUT0,
      CMD_BRD_START,
      CMD_BC_RD,
      CMD_BC_WR,
      CMD_BR_RD,
      CMD_BR_WR,
      CMD_NEXT,
      CMD_FILL_START,
      CMD_F0,
      CMD_F1,
      CMD_F2,
      CMD_F3,
      CMD_F4,
      CMD_BUILD_RESP
   } cmd_type;

   typedef struct packed {
      logic col_last;
      logic row_last;
      logic lvl_last;
      logic fresh;
      logic fill_col_more;
      logic fill_row_more;
   } status_type;

endpackage

/* hdl/mcb_ctrl.sv */
module mcb_ctrl (
   input  logic                clock,
   input  logic                reset,
   input  logic                req_valid,
   input  mcb_pkg::op_type     req_op,
   output logic                req_ready,
   output logic                rsp_valid,
   input  logic                rsp_ready,
   input  mcb_pkg::status_type status,
   output mcb_pkg::cmd_type    cmd
);
   import mcb_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE,
      S_READ,
      S_BRD_START,
      S_BC_RD,
      S_BC_WR,
      S_BR_RD,
      S_BR_WR,
      S_NEXT,
      S_FILL_START,
      S_F0,
      S_F1,
      S_F2,
      S_F3,
      S_F4,
      S_DONE
   } state_type;

   state_type state_ff, state_in;
   logic      rsp_valid_ff, rsp_valid_in;
   logic      accept;

   assign req_ready = (state_ff == S_IDLE) && (!rsp_valid_ff || rsp_ready);
   assign accept    = req_valid && req_ready;
   assign rsp_valid = rsp_valid_ff;

   always_comb begin
      state_in     = state_ff;
      cmd          = CMD_NONE;
      rsp_valid_in = rsp_valid_ff && !rsp_ready;
      unique case (state_ff)
         S_IDLE: begin
            if (accept) begin
               unique case (req_op)
                  OP_LOAD: cmd = CMD_LOAD;
                  OP_READ: begin
                     cmd      = CMD_READ;
                     state_in = S_READ;
                  end
                  OP_QUERY: begin
                     cmd          = CMD_QUERY_RESP;
                     rsp_valid_in = 1'b1;
                  end
                  OP_BUILD: begin
                     cmd      = CMD_LAYOUT0;
                     state_in = S_BRD_START;
                  end
               endcase
            end
         end
         S_READ: begin
            cmd          = CMD_READ_RESP;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         S_BRD_START: begin
            cmd      = CMD_BRD_START;
            state_in = S_BC_RD;
         end
         S_BC_RD: begin
            cmd      = CMD_BC_RD;
            state_in = S_BC_WR;
         end
         S_BC_WR: begin
            cmd      = CMD_BC_WR;
            state_in = status.col_last ? S_BR_RD : S_BC_RD;
         end
         S_BR_RD: begin
            cmd      = CMD_BR_RD;
            state_in = S_BR_WR;
         end
         S_BR_WR: begin
            cmd      = CMD_BR_WR;
            state_in = status.row_last ? S_NEXT : S_BR_RD;
         end
         S_NEXT: begin
            cmd = CMD_NEXT;
            priority if (status.lvl_last) state_in = S_DONE;
            else if (status.fresh)        state_in = S_FILL_START;
            else                          state_in = S_NEXT;
         end
         S_FILL_START: begin
            cmd      = CMD_FILL_START;
            state_in = S_F0;
         end
         S_F0: begin
            cmd      = CMD_F0;
            state_in = S_F1;
         end
         S_F1: begin
            cmd      = CMD_F1;
            state_in = S_F2;
         end
         S_F2: begin
            cmd      = CMD_F2;
            state_in = S_F3;
         end
         S_F3: begin
            cmd      = CMD_F3;
            state_in = S_F4;
         end
         S_F4: begin
            cmd      = CMD_F4;
            state_in = (status.fill_col_more || status.fill_row_more) ? S_F0 : S_BRD_START;
         end
         S_DONE: begin
            cmd          = CMD_BUILD_RESP;
            rsp_valid_in = 1'b1;
            state_in     = S_IDLE;
         end
         default: state_in = S_IDLE;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

endmodule

/* hdl/mcb_dpath.sv */
module mcb_dpath #(
   parameter int LEVEL_COUNT   = 14,
   parameter int MAX_INPUT_DIM = 256,
   parameter int STORE_DEPTH   = 131072
) (
   input  logic                                clock,
   input  logic                                reset,
   input  mcb_pkg::cmd_type                    cmd,
   output mcb_pkg::status_type                 status,
   input  logic                                csr_valid,
   input  logic [mcb_pkg::CSR_IDX_W-1:0]       csr_index,
   input  logic [mcb_pkg::CFG_W-1:0]           csr_wdata,
   input  logic [mcb_pkg::PIX_W-1:0]           req_pixel_in,
   input  logic [mcb_pkg::ADDR_IN_W-1:0]       req_read_address,
   input  logic [mcb_pkg::LSEL_W-1:0]          req_level_select,
   output logic [mcb_pkg::PIX_W-1:0]           rsp_pixel_out,
   output logic [mcb_pkg::ADDR_IN_W-1:0]       rsp_stored_size,
   output logic [mcb_pkg::ADDR_IN_W-1:0]       rsp_level_offset,
   output logic [mcb_pkg::DIM_OUT_W-1:0]       rsp_level_width,
   output logic [mcb_pkg::DIM_OUT_W-1:0]       rsp_level_height,
   output logic                                rsp_out_of_range
);
   import mcb_pkg::*;

   localparam int DIM_W  = $clog2(MAX_INPUT_DIM + 2);
   localparam int TOT_W  = 2 * DIM_W + 1;
   localparam int SA_W   = $clog2(STORE_DEPTH);
   localparam int ADR_W0 = (TOT_W > SA_W) ? TOT_W : SA_W;
   localparam int ADR_W  = ((ADR_W0 > ADDR_IN_W) ? ADR_W0 : ADDR_IN_W) + 1;
   localparam int LV_W   = (LEVEL_COUNT > 1) ? $clog2(LEVEL_COUNT) : 1;
   localparam int SUM_W  = 10;

   // configuration
   logic [CFG_W-1:0] width_ff, height_ff;
   logic             mips_ff;
   logic [2:0]       chan_ff;

   logic [DIM_W-1:0] load_col_ff, load_row_ff;
   logic [ADR_W-1:0] total_ff;
   logic [ADR_W-1:0] off_tab_ff [LEVEL_COUNT];
   logic [DIM_W-1:0] w_tab_ff   [LEVEL_COUNT];
   logic [DIM_W-1:0] h_tab_ff   [LEVEL_COUNT];
   logic [LV_W-1:0]  lvl_ff;

   logic [ADR_W-1:0] cur_o_ff, prv_o_ff;
   logic [DIM_W-1:0] cur_w_ff, cur_h_ff, prv_w_ff, prv_h_ff;
   logic [ADR_W-1:0] ptr_ff;
   logic [DIM_W-1:0] by_ff, bx_ff;
   logic [ADR_W-1:0] srow_ff, sptr_ff, drow_ff, dptr_ff;
   logic [DIM_W-1:0] sx_ff, sy_ff;
   logic [SUM_W-1:0] sum_ff [CHAN_N];
   logic             rd_oor_ff, rd_sto_ff;
   logic [PIX_W-1:0] mem_q_ff;
   logic [PIX_W-1:0] mem [STORE_DEPTH];

   logic [DIM_W-1:0] w_cl, h_cl, w0, h0, nw, nh;
   logic [DIM_W-1:0] col_eff, row_eff;
   logic [DIM_W:0]   col_nx, row_nx;
   logic [ADR_W-1:0] load_addr, area;
   logic [PIX_W-1:0] chan_mask, q_eff, avg;
   logic [LV_W-1:0]  lvl_nx, qsel;
   logic             mem_we, mem_re;
   logic [ADR_W-1:0] mem_waddr, mem_raddr;
   logic [PIX_W-1:0] mem_wdata;

   function automatic logic [DIM_W-1:0] clamp_dim(input logic [CFG_W-1:0] v);
      logic [DIM_W-1:0] r;
      if (v == '0) r = DIM_W'(1);
      else if (v > MAX_INPUT_DIM) r = DIM_W'(MAX_INPUT_DIM);
      else r = DIM_W'(v);
      return r;
   endfunction

   assign w_cl = clamp_dim(width_ff);
   assign h_cl = clamp_dim(height_ff);
   assign w0   = w_cl + 1'b1;
   assign h0   = h_cl + 1'b1;
   assign nw   = (cur_w_ff >> 1) + 1'b1;
   assign nh   = (cur_h_ff >> 1) + 1'b1;
   assign area = ADR_W'(nw) * ADR_W'(nh);

   always_comb begin
      unique case (chan_ff)
         3'd0, 3'd1: chan_mask = 32'h0000_00ff;
         3'd2:       chan_mask = 32'h0000_ffff;
         3'd3:       chan_mask = 32'h00ff_ffff;
         default:    chan_mask = 32'hffff_ffff;
      endcase
   end

   assign col_eff   = (load_col_ff >= w_cl) ? '0 : load_col_ff;
   assign row_eff   = (load_row_ff >= h_cl) ? '0 : load_row_ff;
   assign col_nx    = {1'b0, col_eff} + 1'b1;
   assign row_nx    = {1'b0, row_eff} + 1'b1;
   assign load_addr = ADR_W'(row_eff) * ADR_W'(w0) + ADR_W'(col_eff);

   assign q_eff = rd_sto_ff ? '0 : mem_q_ff;

   always_comb begin
      for (int k = 0; k < CHAN_N; k++) begin
         logic [SUM_W-1:0] s;
         s = sum_ff[k] + SUM_W'(q_eff[8*k +: 8]);
         avg[8*k +: 8] = s[SUM_W-1:2];
      end
   end

   assign lvl_nx = LV_W'(lvl_ff + 1'b1);
   assign qsel   = (req_level_select >= LEVEL_COUNT) ? LV_W'(LEVEL_COUNT - 1)
                                                     : req_level_select[LV_W-1:0];

   assign status.col_last      = (by_ff == cur_h_ff - 1'b1);
   assign status.row_last      = (bx_ff == cur_w_ff - 1'b1);
   assign status.lvl_last      = (lvl_ff == LV_W'(LEVEL_COUNT - 1));
   assign status.fresh         = mips_ff && ((cur_w_ff > 1) || (cur_h_ff > 1));
   assign status.fill_col_more = ((DIM_W+2)'(sx_ff) + (DIM_W+2)'(3)) < (DIM_W+2)'(prv_w_ff);
   assign status.fill_row_more = ((DIM_W+2)'(sy_ff) + (DIM_W+2)'(3)) < (DIM_W+2)'(prv_h_ff);

   always_comb begin
      mem_we    = 1'b0;
      mem_re    = 1'b0;
      mem_waddr = load_addr;
      mem_wdata = q_eff;
      mem_raddr = sptr_ff;
      unique case (cmd)
         CMD_LOAD: begin
            mem_we    = 1'b1;
            mem_wdata = req_pixel_in & chan_mask;
         end
         CMD_READ: begin
            mem_re    = 1'b1;
            mem_raddr = ADR_W'(req_read_address);
         end
         CMD_BC_RD: begin
            mem_re    = 1'b1;
            mem_raddr = ptr_ff;
         end
         CMD_BC_WR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff + ADR_W'(cur_w_ff) - 1'b1;
         end
         CMD_BR_RD: begin
            mem_re    = 1'b1;
            mem_raddr = cur_o_ff + ADR_W'(bx_ff);
         end
         CMD_BR_WR: begin
            mem_we    = 1'b1;
            mem_waddr = ptr_ff + ADR_W'(bx_ff);
         end
         CMD_F0: begin
            mem_re    = 1'b1;
            mem_raddr = sptr_ff;
         end
         CMD_F1: begin
            mem_re    = 1'b1;
            mem_raddr = sptr_ff + 1'b1;
         end
         CMD_F2: begin
            mem_re    = 1'b1;
            mem_raddr = sptr_ff + ADR_W'(prv_w_ff);
         end
         CMD_F3: begin
            mem_re    = 1'b1;
            mem_raddr = sptr_ff + ADR_W'(prv_w_ff) + 1'b1;
         end
         CMD_F4: begin
            mem_we    = 1'b1;
            mem_waddr = dptr_ff;
            mem_wdata = avg;
         end
         default: begin
            mem_we = 1'b0;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (mem_we && (mem_waddr < ADR_W'(STORE_DEPTH))) begin
         mem[mem_waddr[SA_W-1:0]] <= mem_wdata;
      end
      if (mem_re) begin
         mem_q_ff  <= mem[mem_raddr[SA_W-1:0]];
         rd_sto_ff <= (mem_raddr >= ADR_W'(STORE_DEPTH));
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         width_ff    <= CFG_W'(1);
         height_ff   <= CFG_W'(1);
         mips_ff     <= 1'b1;
         chan_ff     <= 3'd4;
         load_col_ff <= '0;
         load_row_ff <= '0;
         total_ff    <= '0;
         lvl_ff      <= '0;
         for (int i = 0; i < LEVEL_COUNT; i++) begin
            off_tab_ff[i] <= '0;
            w_tab_ff[i]   <= '0;
            h_tab_ff[i]   <= '0;
         end
      end else begin
         if (csr_valid) begin
            unique case (csr_index)
               REG_WIDTH_IN:  width_ff  <= csr_wdata;
               REG_HEIGHT_IN: height_ff <= csr_wdata;
               REG_MIPS:      mips_ff   <= csr_wdata[0];
               REG_CHANNELS:  chan_ff   <= csr_wdata[2:0];
            endcase
         end
         unique case (cmd)
            CMD_LOAD: begin
               if (col_nx >= {1'b0, w_cl}) begin
                  load_col_ff <= '0;
                  load_row_ff <= (row_nx >= {1'b0, h_cl}) ? '0 : row_nx[DIM_W-1:0];
               end else begin
                  load_col_ff <= col_nx[DIM_W-1:0];
                  load_row_ff <= row_eff;
               end
            end
            CMD_LAYOUT0: begin
               total_ff      <= ADR_W'(w0) * ADR_W'(h0);
               off_tab_ff[0] <= '0;
               w_tab_ff[0]   <= w0;
               h_tab_ff[0]   <= h0;
               lvl_ff        <= '0;
            end
            CMD_NEXT: begin
               if (!status.lvl_last) begin
                  lvl_ff <= lvl_nx;
                  if (status.fresh) begin
                     off_tab_ff[lvl_nx] <= total_ff;
                     w_tab_ff[lvl_nx]   <= nw;
                     h_tab_ff[lvl_nx]   <= nh;
                     total_ff           <= total_ff + area;
                  end else begin
                     off_tab_ff[lvl_nx] <= cur_o_ff;
                     w_tab_ff[lvl_nx]   <= cur_w_ff;
                     h_tab_ff[lvl_nx]   <= cur_h_ff;
                  end
               end
            end
            default: begin
               lvl_ff <= lvl_ff;
            end
         endcase
      end
   end

   always_ff @(posedge clock) begin
      unique case (cmd)
         CMD_READ: begin
            rd_oor_ff <= (ADR_W'(req_read_address) >= total_ff);
         end
         CMD_READ_RESP: begin
            rsp_pixel_out    <= rd_oor_ff ? '0 : (q_eff & chan_mask);
            rsp_out_of_range <= rd_oor_ff;
            rsp_stored_size  <= '0;
            rsp_level_offset <= '0;
            rsp_level_width  <= '0;
            rsp_level_height <= '0;
         end
         CMD_QUERY_RESP: begin
            rsp_pixel_out    <= '0;
            rsp_out_of_range <= 1'b0;
            rsp_stored_size  <= '0;
            rsp_level_offset <= ADDR_IN_W'(off_tab_ff[qsel]);
            rsp_level_width  <= DIM_OUT_W'(w_tab_ff[qsel]);
            rsp_level_height <= DIM_OUT_W'(h_tab_ff[qsel]);
         end
         CMD_BUILD_RESP: begin
            rsp_pixel_out    <= '0;
            rsp_out_of_range <= 1'b0;
            rsp_stored_size  <= ADDR_IN_W'(total_ff);
            rsp_level_offset <= '0;
            rsp_level_width  <= '0;
            rsp_level_height <= '0;
         end
         CMD_LAYOUT0: begin
            cur_o_ff <= '0;
            cur_w_ff <= w0;
            cur_h_ff <= h0;
         end
         CMD_NEXT: begin
            if (!status.lvl_last && status.fresh) begin
               prv_o_ff <= cur_o_ff;
               prv_w_ff <= cur_w_ff;
               prv_h_ff <= cur_h_ff;
               cur_o_ff <= total_ff;
               cur_w_ff <= nw;
               cur_h_ff <= nh;
            end
         end
         CMD_BRD_START: begin
            ptr_ff <= cur_o_ff;
            by_ff  <= '0;
            bx_ff  <= '0;
         end
         CMD_BC_WR: begin
            if (!status.col_last) begin
               ptr_ff <= ptr_ff + ADR_W'(cur_w_ff);
               by_ff  <= by_ff + 1'b1;
            end
         end
         CMD_BR_WR: begin
            bx_ff <= bx_ff + 1'b1;
         end
         CMD_FILL_START: begin
            srow_ff <= prv_o_ff;
            sptr_ff <= prv_o_ff;
            drow_ff <= cur_o_ff;
            dptr_ff <= cur_o_ff;
            sx_ff   <= '0;
            sy_ff   <= '0;
         end
         CMD_F1: begin
            for (int k = 0; k < CHAN_N; k++) sum_ff[k] <= SUM_W'(q_eff[8*k +: 8]);
         end
         CMD_F2, CMD_F3: begin
            for (int k = 0; k < CHAN_N; k++) sum_ff[k] <= sum_ff[k] + SUM_W'(q_eff[8*k +: 8]);
         end
         CMD_F4: begin
            if (status.fill_col_more) begin
               sx_ff   <= sx_ff + 2'd2;
               sptr_ff <= sptr_ff + 2'd2;
               dptr_ff <= dptr_ff + 1'b1;
            end else begin
               sx_ff   <= '0;
               sy_ff   <= sy_ff + 2'd2;
               srow_ff <= srow_ff + ADR_W'({prv_w_ff, 1'b0});
               sptr_ff <= srow_ff + ADR_W'({prv_w_ff, 1'b0});
               drow_ff <= drow_ff + ADR_W'(cur_w_ff);
               dptr_ff <= drow_ff + ADR_W'(cur_w_ff);
            end
         end
         default: begin
            rd_oor_ff <= rd_oor_ff;
         end
      endcase
   end

endmodule

/* hdl/mip_chain_builder_linear_core.sv */
// query response is valid in the cycle after it is taken; a read passes the texel store output
// register, then the response register. One load or query per cycle while no response stalls;
// none while a read or build runs. A build uses a read and a write per border texel, four reads
// and a write per averaged texel of every new level, one store read and one write at a time
// reset: synchronous, clears load position, level tables, total size and config to defaults;
//   the texel store is not cleared
module mip_chain_builder_linear_core #(
   parameter int LEVEL_COUNT   = 14,
   parameter int MAX_INPUT_DIM = 256,
   parameter int STORE_DEPTH   = 131072
) (
   input  logic                              clock,
   input  logic                              reset,
   input  logic                              req_valid,
   output logic                              req_ready,
   input  logic [1:0]                        req_operation,
   input  logic [mcb_pkg::PIX_W-1:0]         req_pixel_in,
   input  logic [mcb_pkg::ADDR_IN_W-1:0]     req_read_address,
   input  logic [mcb_pkg::LSEL_W-1:0]        req_level_select,
   output logic                              rsp_valid,
   input  logic                              rsp_ready,
   output logic [mcb_pkg::PIX_W-1:0]         rsp_pixel_out,
   output logic [mcb_pkg::ADDR_IN_W-1:0]     rsp_stored_size,
   output logic [mcb_pkg::ADDR_IN_W-1:0]     rsp_level_offset,
   output logic [mcb_pkg::DIM_OUT_W-1:0]     rsp_level_width,
   output logic [mcb_pkg::DIM_OUT_W-1:0]     rsp_level_height,
   output logic                              rsp_out_of_range,
   input  logic                              csr_valid,
   output logic                              csr_ready,
   input  logic [mcb_pkg::CSR_IDX_W-1:0]     csr_index,
   input  logic [mcb_pkg::CFG_W-1:0]         csr_wdata
);
   import mcb_pkg::*;

   cmd_type    cmd;
   status_type status;

   assign csr_ready = 1'b1;

   mcb_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_op    (op_type'(req_operation)),
      .req_ready (req_ready),
      .rsp_valid (rsp_valid),
      .rsp_ready (rsp_ready),
      .status    (status),
      .cmd       (cmd)
   );

   mcb_dpath #(
      .LEVEL_COUNT   (LEVEL_COUNT),
      .MAX_INPUT_DIM (MAX_INPUT_DIM),
      .STORE_DEPTH   (STORE_DEPTH)
   ) u_dpath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .csr_valid        (csr_valid),
      .csr_index        (csr_index),
      .csr_wdata        (csr_wdata),
      .req_pixel_in     (req_pixel_in),
      .req_read_address (req_read_address),
      .req_level_select (req_level_select),
      .rsp_pixel_out    (rsp_pixel_out),
      .rsp_stored_size  (rsp_stored_size),
      .rsp_level_offset (rsp_level_offset),
      .rsp_level_width  (rsp_level_width),
      .rsp_level_height (rsp_level_height),
      .rsp_out_of_range (rsp_out_of_range)
   );

`ifndef SYNTHESIS
   a_ready_rsp_free: assert property (@(posedge clock) disable iff (reset)
      req_ready |-> (!rsp_valid || rsp_ready))
      else $error("input taken while a response is stuck");

   a_oor_zero: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_out_of_range) |-> (rsp_pixel_out == '0))
      else $error("out of range read with nonzero texel");

   a_read_resp: assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && (req_operation == OP_READ)) |=> ##1 rsp_valid)
      else $error("read response missing");
`endif

endmodule
